@@ rtl/core/wav_hdr_pkg.sv @@
// Shared types, constants and codes for the WAV header chunk parser.
package wav_hdr_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h52494646;
  localparam logic [31:0] TAG_WAVE = 32'h57415645;
  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;
  localparam int unsigned FMT_SKIP_BYTES = 6;
  localparam int unsigned BITS_PER_BYTE  = 8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ST_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ST_MISSING   = 3'd3;
  localparam logic [2:0] ST_ZERO_DIV  = 3'd4;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } wav_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] rate_hz;
    logic [15:0] chan_count;
    logic [15:0] sample_width;
    logic [31:0] data_len;
    logic [31:0] audio_start;
    logic [31:0] sample_total;
    logic [31:0] play_secs;
  } wav_out_t;

  // Job handed from the parser to the divider side: all fields but the two quotients.
  typedef struct packed {
    wav_out_t   res;
    logic       need_div;
  } wav_job_t;

endpackage

@@ rtl/core/wav_hdr_front.sv @@
// Byte-level RIFF/WAVE chunk walker that produces one job per file.
module wav_hdr_front
  import wav_hdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  wav_in_t  in_item,
  output logic     job_valid,
  output wav_job_t job
);

  localparam logic [2:0] PH_RIFF = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_WAVE = 3'd2;
  localparam logic [2:0] PH_HDR  = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;
  localparam logic [2:0] PH_PAD  = 3'd5;
  localparam logic [2:0] PH_DONE = 3'd6;

  logic [2:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        fmt_r, fmt_nxt;

  logic [2:0]  ph;
  logic [3:0]  cn;
  logic [31:0] tg, ln, lf, ps, off, shifted;
  logic [15:0] ch, bt;
  logic [31:0] rt;
  logic        fs;
  logic [7:0]  b;
  logic        emit;
  wav_job_t    j;

  // Walk one byte through the chunk structure.
  always_comb begin
    b = in_item.data_byte;
    if (in_item.first_byte) begin
      ph = PH_RIFF; cn = '0; tg = '0; ln = '0; lf = '0; ps = '0;
      ch = '0; rt = '0; bt = '0; fs = 1'b0;
    end else begin
      ph = phase_r; cn = cnt_r; tg = tag_r; ln = len_r; lf = left_r; ps = pos_r;
      ch = chan_r; rt = rate_r; bt = bits_r; fs = fmt_r;
    end
    phase_nxt = ph; cnt_nxt = cn; tag_nxt = tg; len_nxt = ln; left_nxt = lf;
    chan_nxt = ch; rate_nxt = rt; bits_nxt = bt; fmt_nxt = fs;
    pos_nxt = ps + 32'd1;
    emit = 1'b0;
    j = '0;
    shifted = {tg[23:0], b};
    off = ln - lf;
    case (ph)
      PH_RIFF, PH_WAVE: begin
        tag_nxt = shifted;
        cnt_nxt = cn + 4'd1;
        if (cn == 4'd3) begin
          cnt_nxt = '0;
          if (ph == PH_RIFF) begin
            if (shifted != TAG_RIFF) begin
              emit = 1'b1; j.res.status = ST_NOT_RIFF; phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_SIZE;
            end
          end else begin
            if (shifted != TAG_WAVE) begin
              emit = 1'b1; j.res.status = ST_NOT_WAVE; phase_nxt = PH_DONE;
            end else begin
              phase_nxt = PH_HDR;
            end
          end
        end
      end
      PH_SIZE: begin
        cnt_nxt = cn + 4'd1;
        if (cn == 4'd3) begin
          cnt_nxt = '0;
          phase_nxt = PH_WAVE;
        end
      end
      PH_HDR: begin
        if (cn < 4'd4) begin
          tag_nxt = shifted;
          if (cn == 4'd0) len_nxt = '0;
        end else begin
          case (cn[1:0])
            2'd0: len_nxt[7:0]   = b;
            2'd1: len_nxt[15:8]  = b;
            2'd2: len_nxt[23:16] = b;
            default: len_nxt[31:24] = b;
          endcase
        end
        cnt_nxt = cn + 4'd1;
        if (cn == 4'd7) begin
          cnt_nxt = '0;
          if (tag_nxt == TAG_DATA) begin
            emit = 1'b1;
            phase_nxt = PH_DONE;
            j.res.data_len = len_nxt;
            j.res.audio_start = ps + 32'd1;
            j.res.rate_hz = rt;
            j.res.chan_count = ch;
            j.res.sample_width = bt;
            j.res.status = fs ? ST_OK : ST_MISSING;
            j.need_div = fs;
          end else begin
            if (tag_nxt == TAG_FMT) begin
              chan_nxt = '0; rate_nxt = '0; bits_nxt = '0; fmt_nxt = 1'b1;
            end
            left_nxt = len_nxt;
            if (len_nxt == '0) phase_nxt = len_nxt[0] ? PH_PAD : PH_HDR;
            else phase_nxt = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (tg == TAG_FMT) begin
          case (off)
            32'd2: chan_nxt[7:0] = b;
            32'd3: chan_nxt[15:8] = b;
            32'd4: rate_nxt[7:0] = b;
            32'd5: rate_nxt[15:8] = b;
            32'd6: rate_nxt[23:16] = b;
            32'd7: rate_nxt[31:24] = b;
            32'd8 + FMT_SKIP_BYTES: bits_nxt[7:0] = b;
            32'd9 + FMT_SKIP_BYTES: bits_nxt[15:8] = b;
            default: ;
          endcase
        end
        left_nxt = lf - 32'd1;
        if (lf == 32'd1) begin
          phase_nxt = ln[0] ? PH_PAD : PH_HDR;
          cnt_nxt = '0;
        end
      end
      PH_PAD: begin
        phase_nxt = PH_HDR;
        cnt_nxt = '0;
      end
      default: phase_nxt = PH_DONE;
    endcase
    // End of file before a result: report what is missing.
    if (in_item.last_byte && !emit && phase_nxt != PH_DONE) begin
      emit = 1'b1;
      j = '0;
      j.res.rate_hz = rate_nxt;
      j.res.chan_count = chan_nxt;
      j.res.sample_width = bits_nxt;
      if (phase_nxt == PH_RIFF) j.res.status = ST_NOT_RIFF;
      else if (phase_nxt == PH_SIZE || phase_nxt == PH_WAVE) j.res.status = ST_NOT_WAVE;
      else j.res.status = ST_MISSING;
    end
    if (in_item.last_byte) phase_nxt = PH_DONE;
  end

  // Advance state on each accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF; cnt_r <= '0; tag_r <= '0; len_r <= '0; left_r <= '0;
      pos_r <= '0; chan_r <= '0; rate_r <= '0; bits_r <= '0; fmt_r <= 1'b0;
    end else if (in_valid) begin
      phase_r <= phase_nxt; cnt_r <= cnt_nxt; tag_r <= tag_nxt; len_r <= len_nxt;
      left_r <= left_nxt; pos_r <= pos_nxt; chan_r <= chan_nxt; rate_r <= rate_nxt;
      bits_r <= bits_nxt; fmt_r <= fmt_nxt;
    end
  end

  assign job_valid = in_valid && emit;
  assign job = j;

  // Count stays inside the eight-byte chunk header.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r < 4'd8)
    else $error("header byte count out of range");
  // A job is produced only while not done, or on a restart.
  a_job_phase: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (phase_r != PH_DONE || in_item.first_byte))
    else $error("job from finished file");
  // Body phase always has bytes left.
  a_body_left: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |-> left_r != '0)
    else $error("body phase with no bytes left");

endmodule

@@ rtl/core/wav_hdr_back.sv @@
// Result side: up to two sequential divisions per file, then a one-entry result register.
module wav_hdr_back
  import wav_hdr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     job_valid,
  input  wav_job_t job,
  output logic     job_ready,
  output logic     out_empty,
  input  logic     out_pop,
  output wav_out_t out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV1 = 2'd1;
  localparam logic [1:0] S_DIV2 = 2'd2;
  localparam logic [1:0] S_FULL = 2'd3;

  logic [1:0]  state_r, state_nxt;
  wav_out_t    res_r, res_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [31:0] divisor;
  logic [32:0] trial;

  // Channels times whole bytes per sample (the product always fits in 32 bits).
  always_comb begin
    divisor = {16'd0, job.res.chan_count} *
              {19'd0, job.res.sample_width[15:3]};
  end

  assign trial = {rem_r[31:0], quo_r[31]} - {1'b0, dvs_r};

  // Restoring division, one quotient bit per cycle.
  always_comb begin
    state_nxt = state_r; res_nxt = res_r; quo_nxt = quo_r; rem_nxt = rem_r;
    dvs_nxt = dvs_r; step_nxt = step_r;
    case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          res_nxt = job.res;
          if (!job.need_div) begin
            state_nxt = S_FULL;
          end else if (divisor == '0) begin
            res_nxt.status = ST_ZERO_DIV;
            state_nxt = S_FULL;
          end else begin
            quo_nxt = job.res.data_len; rem_nxt = '0; dvs_nxt = divisor;
            step_nxt = '0; state_nxt = S_DIV1;
          end
        end
      end
      S_DIV1, S_DIV2: begin
        if (!trial[32]) begin
          rem_nxt = {1'b0, trial[31:0]};
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        step_nxt = step_r + 6'd1;
        if (step_r == 6'd31) begin
          if (state_r == S_DIV1) begin
            res_nxt.sample_total = quo_nxt;
            if (res_r.rate_hz == '0) begin
              res_nxt.status = ST_ZERO_DIV;
              state_nxt = S_FULL;
            end else begin
              rem_nxt = '0; dvs_nxt = res_r.rate_hz; step_nxt = '0;
              state_nxt = S_DIV2;
            end
          end else begin
            res_nxt.play_secs = quo_nxt;
            state_nxt = S_FULL;
          end
        end
      end
      default: begin
        if (out_pop) state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
    res_r <= res_nxt; quo_r <= quo_nxt; rem_r <= rem_nxt;
    dvs_r <= dvs_nxt; step_r <= step_nxt;
  end

  assign job_ready = (state_r == S_IDLE);
  assign out_empty = (state_r != S_FULL);
  assign out_item  = res_r;

  // Divider never runs with a zero divisor.
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV1 || state_r == S_DIV2) |-> dvs_r != '0)
    else $error("zero divisor in divider");
  // A held result stays until popped.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FULL && !out_pop) |=> state_r == S_FULL)
    else $error("result dropped");
  // During the rate division the status is still the ok code.
  a_div_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV2) |-> res_r.status == ST_OK)
    else $error("bad status during rate division");

endmodule

@@ rtl/core/wav_hdr_queue.sv @@
// Short job queue between the parser and the divider.
module wav_hdr_queue
  import wav_hdr_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  wav_job_t wr_job,
  output logic     full,
  output logic     rd_valid,
  input  logic     rd_en,
  output wav_job_t rd_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  wav_job_t       mem_r [DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           do_wr, do_rd;

  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && rd_valid;
  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_job = mem_r[rp_r];

  // Store job and advance pointers.
  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_job;
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_wr) - (AW+1)'(do_rd);
    end
  end

endmodule

@@ rtl/core/wav_header_chunk_parser.sv @@
// Top level of the WAV header chunk parser.
// Takes a RIFF/WAVE file one byte per cycle (push/full) and gives one result per
// file (empty/pop). The parser accepts a byte in every cycle while in_full is low.
// After a file's data chunk header the result side runs up to two 32-step restoring
// divisions: only the first when the sample rate is zero, none for a result that
// needs no division or has a zero divisor; an unpopped earlier result delays it. A
// two-entry job queue lets bytes of the next file flow meanwhile; full rises only
// when that queue is full, and no clearing pass is needed after reset.
module wav_header_chunk_parser
  import wav_hdr_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  wav_in_t  in_item,
  output logic     out_empty,
  input  logic     out_pop,
  output wav_out_t out_item
);

  logic     acc, job_valid, q_full, q_valid, q_rd;
  wav_job_t job, q_job;

  assign in_full = q_full;
  assign acc = in_push && !q_full;

  wav_hdr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .in_item(in_item),
    .job_valid(job_valid), .job(job)
  );

  wav_hdr_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(job_valid), .wr_job(job), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_rd), .rd_job(q_job)
  );

  wav_hdr_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(q_valid), .job(q_job), .job_ready(q_rd),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

endmodule

@@ tb/wav_header_chunk_parser_test.sv @@
// Self-checking testbench for the WAV header chunk parser: byte stimulus, header predictor, result check.
module wav_header_chunk_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wav_hdr_pkg::*;

  typedef enum logic [2:0] {
    PH_RIFF, PH_SIZE, PH_WAVE, PH_HDR, PH_BODY, PH_PAD, PH_DONE
  } phase_t;

  logic     clk;
  logic     rst_n;
  logic     in_push;
  logic     in_full;
  wav_in_t  in_item;
  logic     out_empty;
  logic     out_pop;
  wav_out_t out_item;

  wav_header_chunk_parser dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  // Predictor state
  phase_t      hp_phase;
  logic [4:0]  hp_count;
  logic [31:0] hp_tag, hp_len, hp_left, hp_pos, hp_rate;
  logic [15:0] hp_chan, hp_bits;
  logic        hp_fmt_seen;

  wav_out_t header_results[$];
  int unsigned errors, results_seen, items_sent, cycles;
  int unsigned send_idle_pct, pop_idle_pct;
  int unsigned status_hits[5];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic clear_header_state();
    hp_phase = PH_RIFF; hp_count = 0; hp_tag = 0; hp_len = 0; hp_left = 0;
    hp_pos = 0; hp_chan = 0; hp_rate = 0; hp_bits = 0; hp_fmt_seen = 0;
  endtask

  function automatic wav_out_t make_result(logic [2:0] st, logic [31:0] dsz,
                                           logic [31:0] doff, logic [31:0] ns,
                                           logic [31:0] dur);
    wav_out_t r;
    r.status = st; r.rate_hz = hp_rate; r.chan_count = hp_chan;
    r.sample_width = hp_bits; r.data_len = dsz; r.audio_start = doff;
    r.sample_total = ns; r.play_secs = dur;
    return r;
  endfunction

  task automatic end_of_chunk();
    hp_phase = hp_len[0] ? PH_PAD : PH_HDR;
    hp_count = 0;
  endtask

  // Advance the header predictor by one byte
  task automatic predict_header(wav_in_t it);
    logic [7:0]  b;
    bit          got;
    logic [31:0] off, dv, ns;
    logic [2:0]  st;
    b = it.data_byte;
    got = 0;
    if (it.first_byte) clear_header_state();
    case (hp_phase)
      PH_RIFF, PH_WAVE: begin
        hp_tag = {hp_tag[23:0], b};
        hp_count++;
        if (hp_count >= 4) begin
          hp_count = 0;
          if (hp_phase == PH_RIFF) begin
            if (hp_tag != TAG_RIFF) begin
              header_results.push_back(make_result(ST_NOT_RIFF, 0, 0, 0, 0));
              got = 1; hp_phase = PH_DONE;
            end else hp_phase = PH_SIZE;
          end else begin
            if (hp_tag != TAG_WAVE) begin
              header_results.push_back(make_result(ST_NOT_WAVE, 0, 0, 0, 0));
              got = 1; hp_phase = PH_DONE;
            end else hp_phase = PH_HDR;
          end
        end
      end
      PH_SIZE: begin
        hp_count++;
        if (hp_count >= 4) begin
          hp_count = 0; hp_phase = PH_WAVE;
        end
      end
      PH_HDR: begin
        if (hp_count < 4) begin
          hp_tag = {hp_tag[23:0], b};
          if (hp_count == 0) hp_len = 0;
        end else begin
          hp_len = hp_len | (32'(b) << (8 * ((hp_count - 4) & 3)));
        end
        hp_count++;
        if (hp_count >= 8) begin
          hp_count = 0;
          if (hp_tag == TAG_DATA) begin
            off = hp_pos + 1;
            got = 1; hp_phase = PH_DONE;
            if (!hp_fmt_seen) begin
              header_results.push_back(make_result(ST_MISSING, hp_len, off, 0, 0));
            end else begin
              dv = 32'(hp_chan) * 32'(hp_bits / BITS_PER_BYTE);
              if (dv == 0) begin
                header_results.push_back(make_result(ST_ZERO_DIV, hp_len, off, 0, 0));
              end else begin
                ns = hp_len / dv;
                if (hp_rate == 0)
                  header_results.push_back(make_result(ST_ZERO_DIV, hp_len, off, ns, 0));
                else
                  header_results.push_back(make_result(ST_OK, hp_len, off, ns,
                                                       ns / hp_rate));
              end
            end
          end else begin
            if (hp_tag == TAG_FMT) begin
              hp_chan = 0; hp_rate = 0; hp_bits = 0; hp_fmt_seen = 1;
            end
            hp_left = hp_len;
            if (hp_left == 0) end_of_chunk();
            else hp_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        if (hp_tag == TAG_FMT) begin
          off = hp_len - hp_left;
          if (off == 2 || off == 3)
            hp_chan = hp_chan | (16'(b) << (8 * (off - 2)));
          else if (off >= 4 && off <= 7)
            hp_rate = hp_rate | (32'(b) << (8 * (off - 4)));
          else if (off == 8 + FMT_SKIP_BYTES || off == 9 + FMT_SKIP_BYTES)
            hp_bits = hp_bits | (16'(b) << (8 * (off - 8 - FMT_SKIP_BYTES)));
        end
        hp_left--;
        if (hp_left == 0) end_of_chunk();
      end
      PH_PAD: begin
        hp_phase = PH_HDR; hp_count = 0;
      end
      default: hp_phase = PH_DONE;
    endcase
    hp_pos++;
    if (it.last_byte && !got && hp_phase != PH_DONE) begin
      if (hp_phase == PH_RIFF) st = ST_NOT_RIFF;
      else if (hp_phase == PH_SIZE || hp_phase == PH_WAVE) st = ST_NOT_WAVE;
      else st = ST_MISSING;
      header_results.push_back(make_result(st, 0, 0, 0, 0));
    end
    if (it.last_byte) hp_phase = PH_DONE;
  endtask

  // Send one item, with random idle before it; push stays high until the next idle
  task automatic send_byte(logic [7:0] b, bit first, bit last);
    wav_in_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 0;
      @(negedge clk);
    end
    it.data_byte = b; it.first_byte = first; it.last_byte = last;
    in_item <= it;
    in_push <= 1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_header(it);
    items_sent++;
    @(negedge clk);
  endtask

  // Drive the pop side
  always @(negedge clk) begin
    if (rst_n) out_pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // Check each popped result
  always @(posedge clk) begin
    wav_out_t e;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (header_results.size() == 0) begin
        $error("result with no expectation: %p", out_item);
        errors++;
      end else begin
        e = header_results.pop_front();
        if (e.status < 5) status_hits[e.status]++;
        if (out_item.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_item.status); errors++;
        end
        if (out_item.rate_hz !== e.rate_hz) begin
          $error("rate_hz exp %0h got %0h", e.rate_hz, out_item.rate_hz);
          errors++;
        end
        if (out_item.chan_count !== e.chan_count) begin
          $error("chan_count exp %0h got %0h", e.chan_count, out_item.chan_count);
          errors++;
        end
        if (out_item.sample_width !== e.sample_width) begin
          $error("sample_width exp %0h got %0h", e.sample_width,
                 out_item.sample_width);
          errors++;
        end
        if (out_item.data_len !== e.data_len) begin
          $error("data_len exp %0h got %0h", e.data_len, out_item.data_len); errors++;
        end
        if (out_item.audio_start !== e.audio_start) begin
          $error("audio_start exp %0h got %0h", e.audio_start, out_item.audio_start);
          errors++;
        end
        if (out_item.sample_total !== e.sample_total) begin
          $error("sample_total exp %0h got %0h", e.sample_total, out_item.sample_total);
          errors++;
        end
        if (out_item.play_secs !== e.play_secs) begin
          $error("play_secs exp %0h got %0h", e.play_secs,
                 out_item.play_secs);
          errors++;
        end
      end
    end
  end

  task automatic send_word_be(logic [31:0] w, bit first);
    send_byte(w[31:24], first, 0); send_byte(w[23:16], 0, 0);
    send_byte(w[15:8], 0, 0); send_byte(w[7:0], 0, 0);
  endtask

  task automatic send_word_le(logic [31:0] w, bit last);
    send_byte(w[7:0], 0, 0); send_byte(w[15:8], 0, 0);
    send_byte(w[23:16], 0, 0); send_byte(w[31:24], 0, last);
  endtask

  task automatic send_preamble();
    send_word_be(TAG_RIFF, 1);
    send_word_le($urandom, 0);
    send_word_be(TAG_WAVE, 0);
  endtask

  // fmt chunk with given length; body bytes beyond the fields are random
  task automatic send_fmt(logic [31:0] flen, logic [15:0] ch, logic [31:0] rate,
                          logic [15:0] bits);
    logic [7:0] body[16];
    body[0] = $urandom; body[1] = $urandom;
    body[2] = ch[7:0]; body[3] = ch[15:8];
    for (int i = 0; i < 4; i++) body[4 + i] = rate[8 * i +: 8];
    for (int i = 8; i < 14; i++) body[i] = $urandom;
    body[14] = bits[7:0]; body[15] = bits[15:8];
    send_word_be(TAG_FMT, 0);
    send_word_le(flen, 0);
    for (int i = 0; i < flen; i++) send_byte(i < 16 ? body[i] : 8'($urandom), 0, 0);
    if (flen[0]) send_byte($urandom, 0, 0);
  endtask

  task automatic send_junk_chunk(int unsigned len);
    send_word_be($urandom, 0);
    send_word_le(len, 0);
    for (int i = 0; i < len; i++) send_byte($urandom, 0, 0);
    if (len[0]) send_byte($urandom, 0, 0);
  endtask

  task automatic send_data_hdr(logic [31:0] dsz);
    send_word_be(TAG_DATA, 0);
    send_word_le(dsz, 0);
  endtask

  // Drop push, then wait for every expected result
  task automatic drain();
    in_push <= 0;
    while (header_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    @(negedge clk);
  endtask

  // Directed: tag errors, missing chunks, zero divisors, extremes
  task automatic test_directed();
    send_word_be(32'h52494647, 1);
    send_word_be(TAG_RIFF, 1); send_word_le(0, 0); send_word_be(32'h57415646, 0);
    send_byte(8'h52, 1, 1);
    send_preamble(); send_data_hdr(32'hFFFFFFFF);
    send_preamble(); send_fmt(16, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF);
    send_data_hdr(32'hFFFFFFFF);
    send_preamble(); send_fmt(16, 0, 48000, 16); send_data_hdr(1000);
    send_preamble(); send_fmt(16, 2, 0, 16); send_data_hdr(1000);
    send_preamble(); send_fmt(5, 2, 44100, 16); send_junk_chunk(3);
    send_fmt(16, 1, 8000, 8); send_data_hdr(16000);
    send_preamble(); send_junk_chunk(0); send_byte(8'h00, 0, 1);
    send_byte(8'hFF, 0, 0);
    drain();
  endtask

  // Random: mostly well-formed files, some truncated or noisy
  task automatic test_random(int unsigned budget);
    int unsigned start, k;
    start = items_sent;
    while (items_sent - start < budget) begin
      k = $urandom_range(9);
      if (k == 0) begin
        for (int i = $urandom_range(12, 1); i > 0; i--)
          send_byte($urandom, $urandom_range(3) == 0, $urandom_range(7) == 0);
      end else begin
        send_preamble();
        if ($urandom_range(3) == 0) send_junk_chunk($urandom_range(5));
        if (k != 1)
          send_fmt($urandom_range(3) == 0 ? $urandom_range(20) : 16,
                   $urandom_range(3) == 0 ? 16'($urandom) : $urandom_range(8),
                   $urandom_range(3) == 0 ? $urandom : $urandom_range(96000),
                   $urandom_range(3) == 0 ? 16'($urandom) : 8 * $urandom_range(4));
        if (k == 2) send_byte($urandom, 0, 1);
        else send_data_hdr($urandom_range(1) ? $urandom : $urandom_range(1 << 20));
      end
    end
    drain();
  endtask

  initial begin
    rst_n = 0; in_push = 0; in_item = '0; out_pop = 0;
    errors = 0; results_seen = 0; items_sent = 0; cycles = 0;
    send_idle_pct = 0; pop_idle_pct = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
    clear_header_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    test_directed();
    send_idle_pct = 7; pop_idle_pct = 72;
    test_random(560);
    send_idle_pct = 72; pop_idle_pct = 7;
    test_random(560);
    send_idle_pct = 0; pop_idle_pct = 0;
    test_random(560);
    $display("Sent %0d bytes, checked %0d results", items_sent, results_seen);
    $display("Status counts ok/riff/wave/missing/zero: %0d %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4]);
    if (errors == 0 && header_results.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
